FILE: rtl/mbtcp_pkg.sv
package mbtcp_pkg;

    // Input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_TX_BYTE = 2'd0;
    localparam logic [1:0] KIND_WORD    = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_QTY    = 3'd1;
    localparam logic [2:0] ST_RX_FAIL    = 3'd2;
    localparam logic [2:0] ST_TXN_MISM   = 3'd3;
    localparam logic [2:0] ST_UNIT_MISM  = 3'd4;
    localparam logic [2:0] ST_FUNC_MISM  = 3'd5;
    localparam logic [2:0] ST_COUNT_MISM = 3'd6;

    // Protocol constants
    localparam logic [7:0]  FC_READ_HOLD = 8'h03;
    localparam logic [7:0]  MBAP_LENGTH  = 8'h06;
    localparam logic [15:0] MAX_QUANTITY = 16'd125;
    localparam int          FRAME_BYTES  = 12;

    // Response byte positions that are checked
    localparam logic [8:0] POS_TXN_HI = 9'd0;
    localparam logic [8:0] POS_TXN_LO = 9'd1;
    localparam logic [8:0] POS_UNIT   = 9'd6;
    localparam logic [8:0] POS_FUNC   = 9'd7;
    localparam logic [8:0] POS_COUNT  = 9'd8;
    localparam logic [8:0] POS_DATA   = 9'd9;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_WORD   = 2'd1,
        CMD_STATUS = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] txn;
        logic [7:0]  unit;
        logic [15:0] addr;
        logic [6:0]  qty;
        logic [15:0] word;
        logic [6:0]  idx;
        logic [2:0]  status;
        logic        tail_status;
    } t_cmd;

endpackage

FILE: rtl/mbtcp_front.sv
module mbtcp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_unit_id,
    input  logic [15:0]       i_start_address,
    input  logic [15:0]       i_quantity,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output mbtcp_pkg::t_cmd   o_cmd,
    input  logic              i_q_ready
);

    logic        r_busy, n_busy;
    logic [15:0] r_txn_ctr, n_txn_ctr;
    logic [15:0] r_pend_txn, n_pend_txn;
    logic [7:0]  r_pend_unit, n_pend_unit;
    logic [6:0]  r_pend_qty, n_pend_qty;
    logic [8:0]  r_byte_cnt, n_byte_cnt;
    logic [2:0]  r_err, n_err;
    logic [7:0]  r_hi, n_hi;

    logic        accept;
    logic [8:0]  end_pos;
    logic [8:0]  off;
    logic [15:0] txn_inc;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign end_pos = {1'b0, r_pend_qty, 1'b0} + 9'd8;
    assign off     = r_byte_cnt - mbtcp_pkg::POS_DATA;
    assign txn_inc = r_txn_ctr + 16'd1;

    // Hold transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_txn_ctr   <= '0;
            r_pend_txn  <= '0;
            r_pend_unit <= '0;
            r_pend_qty  <= '0;
            r_byte_cnt  <= '0;
            r_err       <= mbtcp_pkg::ST_OK;
            r_hi        <= '0;
        end else begin
            r_busy      <= n_busy;
            r_txn_ctr   <= n_txn_ctr;
            r_pend_txn  <= n_pend_txn;
            r_pend_unit <= n_pend_unit;
            r_pend_qty  <= n_pend_qty;
            r_byte_cnt  <= n_byte_cnt;
            r_err       <= n_err;
            r_hi        <= n_hi;
        end
    end

    // Classify the accepted word and build the command for the back
    always_comb begin
        n_busy      = r_busy;
        n_txn_ctr   = r_txn_ctr;
        n_pend_txn  = r_pend_txn;
        n_pend_unit = r_pend_unit;
        n_pend_qty  = r_pend_qty;
        n_byte_cnt  = r_byte_cnt;
        n_err       = r_err;
        n_hi        = r_hi;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.kind  = mbtcp_pkg::CMD_STATUS;

        if (accept) begin
            priority if (i_action == mbtcp_pkg::ACT_START) begin
                n_busy = 1'b0;
                o_push = 1'b1;
                if (i_quantity == 16'd0 || i_quantity > mbtcp_pkg::MAX_QUANTITY) begin
                    o_cmd.kind   = mbtcp_pkg::CMD_STATUS;
                    o_cmd.status = mbtcp_pkg::ST_BAD_QTY;
                end else begin
                    n_txn_ctr   = txn_inc;
                    n_pend_txn  = txn_inc;
                    n_pend_unit = i_unit_id;
                    n_pend_qty  = i_quantity[6:0];
                    n_byte_cnt  = '0;
                    n_err       = mbtcp_pkg::ST_OK;
                    n_hi        = '0;
                    n_busy      = 1'b1;
                    o_cmd.kind  = mbtcp_pkg::CMD_FRAME;
                    o_cmd.txn   = txn_inc;
                    o_cmd.unit  = i_unit_id;
                    o_cmd.addr  = i_start_address;
                    o_cmd.qty   = i_quantity[6:0];
                end
            end else if (i_action == mbtcp_pkg::ACT_FAIL) begin
                if (r_busy) begin
                    n_busy       = 1'b0;
                    o_push       = 1'b1;
                    o_cmd.kind   = mbtcp_pkg::CMD_STATUS;
                    o_cmd.status = mbtcp_pkg::ST_RX_FAIL;
                end
            end else if (i_action == mbtcp_pkg::ACT_BYTE && r_busy) begin
                // check header fields, first failure sticks
                unique case (r_byte_cnt)
                    mbtcp_pkg::POS_TXN_HI: begin
                        if (r_err == mbtcp_pkg::ST_OK && i_rx_byte != r_pend_txn[15:8])
                            n_err = mbtcp_pkg::ST_TXN_MISM;
                    end
                    mbtcp_pkg::POS_TXN_LO: begin
                        if (r_err == mbtcp_pkg::ST_OK && i_rx_byte != r_pend_txn[7:0])
                            n_err = mbtcp_pkg::ST_TXN_MISM;
                    end
                    mbtcp_pkg::POS_UNIT: begin
                        if (r_err == mbtcp_pkg::ST_OK && i_rx_byte != r_pend_unit)
                            n_err = mbtcp_pkg::ST_UNIT_MISM;
                    end
                    mbtcp_pkg::POS_FUNC: begin
                        if (r_err == mbtcp_pkg::ST_OK && i_rx_byte != mbtcp_pkg::FC_READ_HOLD)
                            n_err = mbtcp_pkg::ST_FUNC_MISM;
                    end
                    mbtcp_pkg::POS_COUNT: begin
                        if (r_err == mbtcp_pkg::ST_OK && i_rx_byte != {r_pend_qty, 1'b0})
                            n_err = mbtcp_pkg::ST_COUNT_MISM;
                    end
                    default: begin
                        // data area: high byte held, word sent on low byte
                        if (r_byte_cnt >= mbtcp_pkg::POS_DATA) begin
                            if (!off[0]) begin
                                n_hi = i_rx_byte;
                            end else if (r_err == mbtcp_pkg::ST_OK) begin
                                o_push     = 1'b1;
                                o_cmd.kind = mbtcp_pkg::CMD_WORD;
                                o_cmd.word = {r_hi, i_rx_byte};
                                o_cmd.idx  = off[7:1];
                            end
                        end
                    end
                endcase

                n_byte_cnt = r_byte_cnt + 9'd1;

                // close the run on the last response byte
                if (r_byte_cnt >= end_pos) begin
                    n_busy = 1'b0;
                    if (o_push) begin
                        o_cmd.tail_status = 1'b1;
                        o_cmd.status      = n_err;
                    end else begin
                        o_push       = 1'b1;
                        o_cmd.kind   = mbtcp_pkg::CMD_STATUS;
                        o_cmd.status = n_err;
                    end
                end
            end else begin
                // drop response bytes while idle and unknown actions
            end
        end
    end

    a_busy_qty_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pend_qty != 7'd0 && {9'd0, r_pend_qty} <= mbtcp_pkg::MAX_QUANTITY))
        else $error("busy with an illegal pending quantity");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_byte_cnt <= end_pos)
        else $error("response byte count ran past the frame end");

    a_frame_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.kind == mbtcp_pkg::CMD_FRAME) |=> (r_busy && r_byte_cnt == 9'd0))
        else $error("request sent without opening a transaction");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_q_ready)
        else $error("command pushed into a full queue");

endmodule

FILE: rtl/mbtcp_queue.sv
module mbtcp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbtcp_pkg::t_cmd   i_cmd,
    output logic              o_ready,
    input  logic              i_pop,
    output mbtcp_pkg::t_cmd   o_head,
    output logic              o_head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mbtcp_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_ready      = r_cnt != CW'(DEPTH);
    assign o_head_valid = r_cnt != '0;
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && o_ready;
    assign do_pop       = i_pop && o_head_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/mbtcp_back.sv
module mbtcp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbtcp_pkg::t_cmd   i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_tx_byte,
    output logic [15:0]       o_reg_word,
    output logic [6:0]        o_word_index,
    output logic [2:0]        o_status,
    output logic              o_last
);

    logic [3:0]  r_beat;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_tx_byte;
    logic [15:0] r_reg_word;
    logic [6:0]  r_word_index;
    logic [2:0]  r_status;
    logic        r_last;

    logic        load;
    logic        beat_last;
    logic [1:0]  n_kind;
    logic [7:0]  n_tx_byte;
    logic [15:0] n_reg_word;
    logic [6:0]  n_word_index;
    logic [2:0]  n_status;
    logic        n_last;

    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load && beat_last;

    // Pick the result word for the current beat of the head command
    always_comb begin
        beat_last    = 1'b1;
        n_kind       = mbtcp_pkg::KIND_STATUS;
        n_tx_byte    = '0;
        n_reg_word   = '0;
        n_word_index = '0;
        n_status     = '0;
        n_last       = 1'b0;
        unique case (i_head.kind)
            mbtcp_pkg::CMD_FRAME: begin
                beat_last = r_beat == 4'(mbtcp_pkg::FRAME_BYTES - 1);
                n_kind    = mbtcp_pkg::KIND_TX_BYTE;
                n_last    = beat_last;
                unique case (r_beat)
                    4'd0:    n_tx_byte = i_head.txn[15:8];
                    4'd1:    n_tx_byte = i_head.txn[7:0];
                    4'd5:    n_tx_byte = mbtcp_pkg::MBAP_LENGTH;
                    4'd6:    n_tx_byte = i_head.unit;
                    4'd7:    n_tx_byte = mbtcp_pkg::FC_READ_HOLD;
                    4'd8:    n_tx_byte = i_head.addr[15:8];
                    4'd9:    n_tx_byte = i_head.addr[7:0];
                    4'd11:   n_tx_byte = {1'b0, i_head.qty};
                    default: n_tx_byte = '0;
                endcase
            end
            mbtcp_pkg::CMD_WORD: begin
                if (i_head.tail_status && r_beat != 4'd0) begin
                    n_kind   = mbtcp_pkg::KIND_STATUS;
                    n_status = i_head.status;
                    n_last   = 1'b1;
                end else begin
                    beat_last    = !i_head.tail_status;
                    n_kind       = mbtcp_pkg::KIND_WORD;
                    n_reg_word   = i_head.word;
                    n_word_index = i_head.idx;
                end
            end
            default: begin
                n_kind   = mbtcp_pkg::KIND_STATUS;
                n_status = i_head.status;
                n_last   = 1'b1;
            end
        endcase
    end

    // Advance the beat counter and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_beat <= beat_last ? 4'd0 : r_beat + 4'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind       <= n_kind;
            r_tx_byte    <= n_tx_byte;
            r_reg_word   <= n_reg_word;
            r_word_index <= n_word_index;
            r_status     <= n_status;
            r_last       <= n_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx_byte;
    assign o_reg_word   = r_reg_word;
    assign o_word_index = r_word_index;
    assign o_status     = r_status;
    assign o_last       = r_last;

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat < 4'(mbtcp_pkg::FRAME_BYTES))
        else $error("frame beat counter out of range");

    a_beat_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> r_beat == 4'd0)
        else $error("beat counter left mid-command with an empty queue");

endmodule

FILE: rtl/modbus_tcp_read_holding_master_top.sv
// Modbus TCP master for function 03 (read holding registers). The block takes one input
// word per cycle while the queue has room: a start (checks quantity 1..125, bumps the
// transaction id and emits the 12 request bytes, last byte flagged), a response byte
// (header checked in order txn id, unit, function, byte count; each register word is
// emitted on its low byte while no error is pending, and a final status with last follows
// byte 9+2*quantity), or a link failure (status 2 if a transaction is open). The front
// classifies and updates transaction state in the cycle the word is accepted and queues a
// command; the back turns each command into registered result words at one per cycle
// while the output is taken. Response bytes yield at most 2 words each and sustain one per
// cycle; the QUEUE_DEPTH-entry queue sets how long input flows as a request frame drains.
module modbus_tcp_read_holding_master_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_unit_id,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_quantity,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_reg_word,
    output logic [6:0]  o_word_index,
    output logic [2:0]  o_status,
    output logic        o_last
);

    logic            push, q_ready, pop, head_valid;
    mbtcp_pkg::t_cmd cmd, head;

    mbtcp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_unit_id       (i_unit_id),
        .i_start_address (i_start_address),
        .i_quantity      (i_quantity),
        .i_rx_byte       (i_rx_byte),
        .o_push          (push),
        .o_cmd           (cmd),
        .i_q_ready       (q_ready)
    );

    mbtcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_ready      (q_ready),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    mbtcp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_reg_word   (o_reg_word),
        .o_word_index (o_word_index),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
